// ===== design/rtc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the radix text converter: sequencer states, ASCII codes,
// register indexes and small helper functions. No dependencies.
package rtc_pkg;

	localparam int CHAR_WIDTH = 8;
	localparam int BASE_WIDTH = 5;
	localparam int DIGIT_WIDTH = 4;

	// Configuration register indexes.
	localparam logic REG_SOURCE_BASE = 1'b0;
	localparam logic REG_DEST_BASE   = 1'b1;

	localparam logic [BASE_WIDTH-1:0] SOURCE_BASE_RESET = 5'd10;
	localparam logic [BASE_WIDTH-1:0] DEST_BASE_RESET   = 5'd16;
	localparam logic [BASE_WIDTH-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_WIDTH-1:0] BASE_MAX = 5'd16;

	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [CHAR_WIDTH-1:0] CASE_OFFSET  = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] DIGIT_TEN    = 8'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_PREP,
		ST_SIGN,
		ST_DIV,
		ST_STORE,
		ST_READ,
		ST_EMIT
	} rtc_state_t;

	// Radix values outside 2..16 are pinned to the nearest limit.
	function automatic logic [BASE_WIDTH-1:0] clamp_base(input logic [BASE_WIDTH-1:0] b);
		logic [BASE_WIDTH-1:0] r;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

	function automatic logic [CHAR_WIDTH-1:0] glyph(input logic [DIGIT_WIDTH-1:0] d);
		logic [CHAR_WIDTH-1:0] g;
		if (d < 4'd10) begin
			g = CHAR_ZERO + CHAR_WIDTH'(d);
		end else begin
			g = CHAR_UPPER_A + CHAR_WIDTH'(d) - DIGIT_TEN;
		end
		return g;
	endfunction

endpackage

// ===== design/rtc_if.sv =====
`timescale 1ns / 1ps
// Streaming channel interfaces of the radix text converter: the incoming
// character channel and the converted character channel. Uses rtc_pkg.
interface rtc_in_if
	import rtc_pkg::*;
();
	logic valid;
	logic ready;
	logic [CHAR_WIDTH-1:0] in_char;
	logic in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface rtc_out_if
	import rtc_pkg::*;
();
	logic valid;
	logic ready;
	logic [CHAR_WIDTH-1:0] out_char;
	logic out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// ===== design/radix_text_converter.sv =====
`timescale 1ns / 1ps
// Top level of the radix text converter: character accumulator, shared
// restoring divider, digit memory and output register. Uses rtc_pkg, rtc_if.
//
// The block reads the ASCII text of a signed number, one character per
// transfer on in_stream, most significant first, with in_last on the final
// character. A leading '-' makes the number negative and lower-case letters
// count as upper case. Every other character adds a digit: value becomes
// value * source_base + digit, wrapping at VALUE_WIDTH bits, where a
// character that is not '0'-'9' counts as its code minus 'A' plus 10,
// unchecked. After the final character the value goes out on out_stream as
// ASCII text in dest_base, most significant first, with out_last on the
// final character: zero gives "0", a negative value gets a leading '-' and
// its magnitude is taken as unsigned. Each character goes through a transfer
// step and then a multiply-add step, during which the input is not ready.
// After the final character a prepare step and a sign step settle the sign,
// and each output digit comes from one shared restoring divider that retires
// one quotient bit a cycle in its divide step; a store step writes the digit
// to the digit memory, and a read step and an emit step read it back and
// present it. The input is not ready while a conversion runs. The user must
// write the base registers through cfg_we / cfg_index / cfg_wdata only while
// the block is idle; the block itself does not enforce this. A base outside
// 2..16 acts as the nearest limit.
module radix_text_converter
	import rtc_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [BASE_WIDTH-1:0] cfg_wdata,
	rtc_in_if.sink                in_stream,
	rtc_out_if.source             out_stream
);

	localparam int W  = VALUE_WIDTH;
	localparam int AW = $clog2(W);
	localparam int CW = $clog2(W + 1);

	rtc_state_t state_q, state_d;

	logic [BASE_WIDTH-1:0] src_base_q, dst_base_q;
	logic [BASE_WIDTH-1:0] src_radix, dst_radix;

	logic [CHAR_WIDTH-1:0] char_q;
	logic                  last_q;
	logic [W-1:0]          acc_q;
	logic                  neg_q;
	logic                  first_q;
	logic [W-1:0]          val_q;
	logic [DIGIT_WIDTH-1:0] rem_q;
	logic [AW-1:0]         bit_cnt_q;
	logic [CW-1:0]         dcnt_q;

	logic [DIGIT_WIDTH-1:0] dmem [W];
	logic [DIGIT_WIDTH-1:0] rd_data_q;
	logic [AW-1:0]          rd_addr;

	logic                  out_valid_q;
	logic [CHAR_WIDTH-1:0] out_char_q;
	logic                  out_last_q;

	// Handshake and control decodes.
	logic in_xfer, out_free;
	logic out_load, clear_num, mem_we;
	logic [CHAR_WIDTH-1:0] out_char_d;
	logic out_last_d;

	// Character decode and multiply-add.
	logic [CHAR_WIDTH-1:0] char_fold;
	logic [CHAR_WIDTH:0]   letter_digit;
	logic [W-1:0]          digit_ext;
	logic [W+BASE_WIDTH-1:0] product;
	logic [W-1:0]          acc_next;
	logic                  is_sign_char;

	// Divider step.
	logic [DIGIT_WIDTH:0]   rem_shift;
	logic                   rem_ge;
	logic [DIGIT_WIDTH-1:0] rem_next;
	logic                   val_zero, val_neg;
	logic [CW-1:0]          dcnt_inc;

	assign src_radix = clamp_base(src_base_q);
	assign dst_radix = clamp_base(dst_base_q);

	assign in_xfer  = in_stream.valid && in_stream.ready;
	assign out_free = !out_valid_q || out_stream.ready;

	always_comb begin
		char_fold = char_q;
		if (char_q >= CHAR_LOWER_A && char_q <= CHAR_LOWER_Z) begin
			char_fold = char_q - CASE_OFFSET;
		end
		// Letter value: code - 'A' + 10, which goes negative for low codes.
		letter_digit = {1'b0, char_fold} - {1'b0, CHAR_UPPER_A - DIGIT_TEN};
		if (char_fold >= CHAR_ZERO && char_fold <= CHAR_NINE) begin
			digit_ext = W'(char_fold - CHAR_ZERO);
		end else begin
			digit_ext = W'($signed(letter_digit));
		end
		product  = acc_q * src_radix;
		acc_next = product[W-1:0] + digit_ext;
	end

	assign is_sign_char = first_q && (char_q == CHAR_MINUS);

	assign rem_shift = {rem_q, val_q[W-1]};
	assign rem_ge    = rem_shift >= dst_radix;
	assign rem_next  = rem_ge ? DIGIT_WIDTH'(rem_shift - dst_radix) : rem_shift[DIGIT_WIDTH-1:0];
	assign val_zero  = (val_q == '0);
	assign val_neg   = val_q[W-1];
	assign dcnt_inc  = dcnt_q + 1'b1;
	assign rd_addr   = AW'(dcnt_q - 1'b1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = last_q ? ST_PREP : ST_IDLE;
			end
			ST_PREP: begin
				state_d = ST_SIGN;
			end
			ST_SIGN: begin
				if (val_zero) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (!val_neg || out_free) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == AW'(W - 1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				state_d = (!val_zero && dcnt_inc < CW'(W)) ? ST_DIV : ST_READ;
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (dcnt_q == CW'(1)) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		in_stream.ready = (state_q == ST_IDLE);
		out_load   = 1'b0;
		clear_num  = 1'b0;
		mem_we     = (state_q == ST_STORE);
		out_char_d = glyph(rd_data_q);
		out_last_d = (dcnt_q == CW'(1));
		unique case (state_q)
			ST_SIGN: begin
				if (val_zero) begin
					out_load   = out_free;
					clear_num  = out_free;
					out_char_d = CHAR_ZERO;
					out_last_d = 1'b1;
				end else if (val_neg) begin
					out_load   = out_free;
					out_char_d = CHAR_MINUS;
					out_last_d = 1'b0;
				end
			end
			ST_EMIT: begin
				out_load  = out_free;
				clear_num = out_free && (dcnt_q == CW'(1));
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= SOURCE_BASE_RESET;
			dst_base_q <= DEST_BASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_BASE: src_base_q <= cfg_wdata;
				REG_DEST_BASE:   dst_base_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and number state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			first_q     <= 1'b1;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				first_q <= 1'b0;
				if (is_sign_char) begin
					neg_q <= 1'b1;
				end else begin
					acc_q <= acc_next;
				end
			end
			if (clear_num) begin
				dcnt_q <= '0;
			end else if (state_q == ST_STORE) begin
				dcnt_q <= dcnt_inc;
			end else if (state_q == ST_EMIT && out_free) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (clear_num) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				first_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: input character, divider, output character.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_q <= in_stream.in_char;
			last_q <= in_stream.in_last;
		end
		unique case (state_q)
			ST_PREP: begin
				val_q <= neg_q ? W'(0) - acc_q : acc_q;
			end
			ST_SIGN: begin
				// The magnitude is taken only when the '-' is handed to the
				// output register, so a stalled sink leaves the value alone.
				if (val_neg && out_free) begin
					val_q <= W'(0) - val_q;
				end
				rem_q     <= '0;
				bit_cnt_q <= '0;
			end
			ST_DIV: begin
				val_q     <= {val_q[W-2:0], rem_ge};
				rem_q     <= rem_next;
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			ST_STORE: begin
				rem_q     <= '0;
				bit_cnt_q <= '0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
	end

	// Digit memory: remainders go in least significant first and are read
	// back from the top down.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[dcnt_q[AW-1:0]] <= rem_q;
		end
		rd_data_q <= dmem[rd_addr];
	end

	assign out_stream.valid    = out_valid_q;
	assign out_stream.out_char = out_char_q;
	assign out_stream.out_last = out_last_q;

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> {1'b0, rem_q} < dst_radix)
		else $error("divider remainder not below the radix");

	a_dcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= CW'(W))
		else $error("digit count exceeds the value width");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_last_d |=> acc_q == '0 && first_q && state_q == ST_IDLE)
		else $error("number state not cleared after the final character");

	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_ACC)
		else $error("accepted character not taken to the accumulate step");

endmodule
